FILE: design/pbrs_pkg.sv
// pbrs_pkg: shared constants, types, microcode table and helper functions
// for the polynomial bisection root solver
// no dependencies
`timescale 1ns / 1ps

package pbrs_pkg;

    // search and polynomial sizes
    localparam int MAX_STEPS  = 50;
    localparam int NUM_COEFFS = 4;

    // number formats (signed Q16.16)
    localparam int DATA_W = 32;
    localparam int TOL_W  = 31;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int ACC_W  = TERM_W + 2;
    localparam int ERR_W  = DATA_W + 1;

    // coefficient store and step counter
    localparam int COEF_SLOTS = 4;
    localparam int K_W        = 2;
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);

    // configuration port
    localparam int CFG_ADDR_W = 3;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_COEF_0    = 3'd0;
    localparam cfg_addr_t REG_COEF_1    = 3'd1;
    localparam cfg_addr_t REG_COEF_2    = 3'd2;
    localparam cfg_addr_t REG_COEF_3    = 3'd3;
    localparam cfg_addr_t REG_X_LOW     = 3'd4;
    localparam cfg_addr_t REG_X_HIGH    = 3'd5;
    localparam cfg_addr_t REG_TOLERANCE = 3'd6;

    // reset values of the configuration registers
    localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sd65536;
    localparam logic signed [DATA_W-1:0] Q_ZERO    = 32'sd0;
    localparam logic        [TOL_W-1:0]  TOL_RESET = 31'd66;

    // rounding constant: one half lsb of the Q16.16 result
    localparam logic signed [PROD_W-1:0] RND_HALF = 64'sd32768;

    // microcode addresses
    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UA_IDLE   = 3'd0;
    localparam upc_t UA_MID    = 3'd1;
    localparam upc_t UA_MULC   = 3'd2;
    localparam upc_t UA_ACCP   = 3'd3;
    localparam upc_t UA_POW    = 3'd4;
    localparam upc_t UA_SAT    = 3'd5;
    localparam upc_t UA_TEST   = 3'd6;
    localparam upc_t UA_FINISH = 3'd7;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_START,
        C_LAST_TERM,
        C_NOT_DONE
    } cond_t;

    typedef enum logic {
        MA_COEF,
        MA_PW
    } mul_a_t;

    typedef enum logic {
        MB_PW,
        MB_MID
    } mul_b_t;

    // one control word per microcode step
    typedef struct packed {
        logic   in_rd;
        logic   mid_ld;
        logic   mul_en;
        mul_a_t mul_a;
        mul_b_t mul_b;
        logic   acc_add;
        logic   pw_ld;
        logic   f_ld;
        logic   test;
        logic   out_wr;
        cond_t  cond;
        upc_t   target;
    } ctrl_t;

    // datapath and output status seen by the sequencer
    typedef struct packed {
        logic start;
        logic last_term;
        logic done;
        logic out_busy;
    } status_t;

    // microcode program
    function automatic ctrl_t ucode(input upc_t addr);
        ctrl_t w;
        w        = '0;
        w.mul_a  = MA_COEF;
        w.mul_b  = MB_PW;
        w.cond   = C_NEXT;
        w.target = UA_IDLE;
        unique case (addr)
            UA_IDLE: begin
                w.in_rd  = 1'b1;
                w.cond   = C_NO_START;
                w.target = UA_IDLE;
            end
            UA_MID: begin
                w.mid_ld = 1'b1;
            end
            UA_MULC: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_COEF;
                w.mul_b  = MB_PW;
            end
            UA_ACCP: begin
                w.acc_add = 1'b1;
                w.mul_en  = 1'b1;
                w.mul_a   = MA_PW;
                w.mul_b   = MB_MID;
                w.cond    = C_LAST_TERM;
                w.target  = UA_SAT;
            end
            UA_POW: begin
                w.pw_ld  = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = UA_MULC;
            end
            UA_SAT: begin
                w.f_ld = 1'b1;
            end
            UA_TEST: begin
                w.test   = 1'b1;
                w.cond   = C_NOT_DONE;
                w.target = UA_MID;
            end
            UA_FINISH: begin
                w.out_wr = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = UA_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

    // saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_data(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] lim_hi;
        logic signed [ACC_W-1:0] lim_lo;
        lim_hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lim_lo = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > lim_hi) begin
            return lim_hi[DATA_W-1:0];
        end else if (v < lim_lo) begin
            return lim_lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    // round a full-width product back to Q16.16 (round half up)
    function automatic logic signed [TERM_W-1:0] round_prod(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] r;
        r = p + RND_HALF;
        return r[PROD_W-1:FRAC_W];
    endfunction

endpackage

FILE: design/pbrs_sequencer.sv
// pbrs_sequencer: microprogram counter, control store lookup and branch logic
// depends on pbrs_pkg
`timescale 1ns / 1ps

module pbrs_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  pbrs_pkg::status_t status,
    output pbrs_pkg::ctrl_t   ctrl
);

    pbrs_pkg::upc_t upc_reg;
    pbrs_pkg::upc_t upc_next;
    logic           taken;
    logic           stall;

    assign ctrl = pbrs_pkg::ucode(upc_reg);

    // hold the finish step while the result register is still occupied
    assign stall = ctrl.out_wr & status.out_busy;

    always_comb begin
        unique case (ctrl.cond)
            pbrs_pkg::C_NEXT:      taken = 1'b0;
            pbrs_pkg::C_ALWAYS:    taken = 1'b1;
            pbrs_pkg::C_NO_START:  taken = ~status.start;
            pbrs_pkg::C_LAST_TERM: taken = status.last_term;
            pbrs_pkg::C_NOT_DONE:  taken = ~status.done;
            default:               taken = 1'b0;
        endcase
    end

    always_comb begin
        priority if (stall) begin
            upc_next = upc_reg;
        end else if (taken) begin
            upc_next = ctrl.target;
        end else begin
            upc_next = upc_reg + pbrs_pkg::upc_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= pbrs_pkg::UA_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: design/pbrs_datapath.sv
// pbrs_datapath: configuration registers, search bounds, shared multiplier,
// power and sum registers, error test
// depends on pbrs_pkg
`timescale 1ns / 1ps

module pbrs_datapath (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  pbrs_pkg::cfg_addr_t                       cfg_addr,
    input  logic        [pbrs_pkg::DATA_W-1:0]        cfg_wr_data,
    input  logic                                      s_valid,
    input  logic signed [pbrs_pkg::DATA_W-1:0]        s_target_value,
    input  pbrs_pkg::ctrl_t                           ctrl,
    output logic                                      start,
    output logic                                      last_term,
    output logic                                      done,
    output logic signed [pbrs_pkg::DATA_W-1:0]        root,
    output logic                                      conv
);

    localparam int DW = pbrs_pkg::DATA_W;

    // configuration
    logic signed [DW-1:0]              coef_reg [pbrs_pkg::COEF_SLOTS];
    logic signed [DW-1:0]              x_low_reg;
    logic signed [DW-1:0]              x_high_reg;
    logic        [pbrs_pkg::TOL_W-1:0] tol_reg;

    // search state
    logic signed [DW-1:0]                 lo_reg;
    logic signed [DW-1:0]                 hi_reg;
    logic signed [DW-1:0]                 y_reg;
    logic signed [DW-1:0]                 mid_reg;
    logic signed [DW-1:0]                 pw_reg;
    logic signed [DW-1:0]                 f_reg;
    logic signed [pbrs_pkg::ACC_W-1:0]    acc_reg;
    logic signed [pbrs_pkg::PROD_W-1:0]   prod_reg;
    logic        [pbrs_pkg::K_W-1:0]      k_reg;
    logic        [pbrs_pkg::STEP_W-1:0]   step_reg;
    logic                                 conv_reg;

    logic                               accept;
    logic signed [DW:0]                 bound_sum;
    logic signed [DW-1:0]               mid_next;
    logic signed [DW-1:0]               mul_a;
    logic signed [DW-1:0]               mul_b;
    logic signed [pbrs_pkg::TERM_W-1:0] term;
    logic signed [pbrs_pkg::ACC_W-1:0]  term_ext;
    logic signed [pbrs_pkg::ERR_W-1:0]  err;
    logic        [pbrs_pkg::ERR_W-1:0]  err_mag;
    logic                               hit;
    logic                               last_step;

    assign accept = ctrl.in_rd & s_valid;

    // midpoint at 33 bits, floor shift by one
    assign bound_sum = {lo_reg[DW-1], lo_reg} + {hi_reg[DW-1], hi_reg};
    assign mid_next  = bound_sum[DW:1];

    assign mul_a = (ctrl.mul_a == pbrs_pkg::MA_COEF) ? coef_reg[k_reg] : pw_reg;
    assign mul_b = (ctrl.mul_b == pbrs_pkg::MB_PW) ? pw_reg : mid_reg;

    assign term     = pbrs_pkg::round_prod(prod_reg);
    assign term_ext = {{(pbrs_pkg::ACC_W-pbrs_pkg::TERM_W){term[pbrs_pkg::TERM_W-1]}}, term};

    // error of f against target and the tolerance test
    assign err       = {f_reg[DW-1], f_reg} - {y_reg[DW-1], y_reg};
    assign err_mag   = err[pbrs_pkg::ERR_W-1] ? (~err + pbrs_pkg::ERR_W'(1)) : err;
    assign hit       = err_mag < {{(pbrs_pkg::ERR_W-pbrs_pkg::TOL_W){1'b0}}, tol_reg};
    assign last_step = step_reg == pbrs_pkg::STEP_W'(pbrs_pkg::MAX_STEPS - 1);

    assign start     = s_valid;
    assign last_term = k_reg == pbrs_pkg::K_W'(pbrs_pkg::NUM_COEFFS - 1);
    assign done      = hit | last_step;
    assign root      = mid_reg;
    assign conv      = conv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= pbrs_pkg::Q_ONE;
            coef_reg[1] <= pbrs_pkg::Q_ZERO;
            coef_reg[2] <= pbrs_pkg::Q_ZERO;
            coef_reg[3] <= pbrs_pkg::Q_ZERO;
            x_low_reg   <= pbrs_pkg::Q_ZERO;
            x_high_reg  <= pbrs_pkg::Q_ONE;
            tol_reg     <= pbrs_pkg::TOL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pbrs_pkg::REG_COEF_0:    coef_reg[0] <= cfg_wr_data;
                pbrs_pkg::REG_COEF_1:    coef_reg[1] <= cfg_wr_data;
                pbrs_pkg::REG_COEF_2:    coef_reg[2] <= cfg_wr_data;
                pbrs_pkg::REG_COEF_3:    coef_reg[3] <= cfg_wr_data;
                pbrs_pkg::REG_X_LOW:     x_low_reg   <= cfg_wr_data;
                pbrs_pkg::REG_X_HIGH:    x_high_reg  <= cfg_wr_data;
                pbrs_pkg::REG_TOLERANCE: tol_reg     <= cfg_wr_data[pbrs_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lo_reg   <= x_low_reg;
            hi_reg   <= x_high_reg;
            y_reg    <= s_target_value;
            step_reg <= '0;
        end
        if (ctrl.mid_ld) begin
            mid_reg <= mid_next;
            pw_reg  <= mid_next;
            acc_reg <= '0;
            k_reg   <= '0;
        end
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctrl.acc_add) begin
            acc_reg <= acc_reg + term_ext;
        end
        if (ctrl.pw_ld) begin
            pw_reg <= pbrs_pkg::sat_data(term_ext);
            k_reg  <= k_reg + pbrs_pkg::K_W'(1);
        end
        if (ctrl.f_ld) begin
            f_reg <= pbrs_pkg::sat_data(acc_reg);
        end
        if (ctrl.test) begin
            conv_reg <= hit;
            if (!hit) begin
                // f below target moves the low bound up
                if (err[pbrs_pkg::ERR_W-1]) begin
                    lo_reg <= mid_reg;
                end else begin
                    hi_reg <= mid_reg;
                end
                step_reg <= step_reg + pbrs_pkg::STEP_W'(1);
            end
        end
    end

endmodule

FILE: design/polynomial_bisection_root_solver.sv
// polynomial_bisection_root_solver: top level, microcoded bisection search
// depends on pbrs_pkg, pbrs_sequencer, pbrs_datapath
// each request runs 1..MAX_STEPS bisection tries before its result is written
// throughput: one request at a time, set by the single shared 32x32 multiplier
// that every power and every term passes through in turn
// reset: aresetn synchronous active low; coefficients return to 1.0, 0, 0, 0,
// bounds to [0, 1.0], tolerance to 66; the sequencer goes idle, no result pending
`timescale 1ns / 1ps

module polynomial_bisection_root_solver (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [pbrs_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [pbrs_pkg::DATA_W-1:0]           cfg_wr_data,
    // request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [pbrs_pkg::DATA_W-1:0]    s_target_value,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pbrs_pkg::DATA_W-1:0]    m_root_estimate,
    output logic                                  m_converged
);

    pbrs_pkg::ctrl_t   ctrl;
    pbrs_pkg::status_t status;

    logic                                 dp_start;
    logic                                 dp_last_term;
    logic                                 dp_done;
    logic signed [pbrs_pkg::DATA_W-1:0]   dp_root;
    logic                                 dp_conv;

    // result register, decoupled from the search so the next request
    // can start while this one waits on the result channel
    logic                                 m_valid_reg;
    logic signed [pbrs_pkg::DATA_W-1:0]   m_root_reg;
    logic                                 m_conv_reg;
    logic                                 out_free;
    logic                                 out_load;

    assign out_free = ~m_valid_reg | m_ready;
    assign out_load = ctrl.out_wr & out_free;

    // status word for the branch conditions of the microprogram
    assign status.start     = dp_start;
    assign status.last_term = dp_last_term;
    assign status.done      = dp_done;
    assign status.out_busy  = ~out_free;

    // requests are taken only at the idle step of the microprogram
    assign s_ready = ctrl.in_rd;

    pbrs_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    pbrs_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_target_value (s_target_value),
        .ctrl           (ctrl),
        .start          (dp_start),
        .last_term      (dp_last_term),
        .done           (dp_done),
        .root           (dp_root),
        .conv           (dp_conv)
    );

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload: last midpoint tested and whether tolerance was met
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_root_reg <= dp_root;
            m_conv_reg <= dp_conv;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_root_estimate = m_root_reg;
    assign m_converged     = m_conv_reg;

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for polynomial_bisection_root_solver
// drives requests and register writes, predicts each result in the bench itself
// depends on pbrs_pkg and the polynomial_bisection_root_solver rtl
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF           = 5;
    localparam int RESET_CYCLES       = 5;
    // worst request: every try taken, four terms per try
    localparam int SOLVE_CYCLES_MAX   =
        2 + pbrs_pkg::MAX_STEPS * (3 * pbrs_pkg::NUM_COEFFS + 2);
    // cycles with no handshake or register write before the run is declared hung
    localparam int WATCHDOG_LIMIT     = 8 * SOLVE_CYCLES_MAX;
    localparam int ITEMS_PER_SETTING  = 150;
    localparam int SETTINGS_PER_PHASE = 3;
    localparam int IDLE_PHASES        = 4;
    localparam int REPORT_LIMIT       = 10;
    localparam int DIRECTED_ROWS      = 36;

    // index with no register behind it
    localparam pbrs_pkg::cfg_addr_t REG_UNUSED = 3'd7;

    localparam logic signed [pbrs_pkg::DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [pbrs_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [pbrs_pkg::DATA_W-1:0] root;
        logic                               converged;
    } root_result_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // one line of the directed table: a request or a register write
    typedef struct packed {
        row_kind_t                   kind;
        pbrs_pkg::cfg_addr_t         addr;
        logic [pbrs_pkg::DATA_W-1:0] value;
        logic                        typed;
        root_result_t                expected;
    } stim_row_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_wr_en;
    pbrs_pkg::cfg_addr_t                cfg_addr;
    logic [pbrs_pkg::DATA_W-1:0]        cfg_wr_data;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [pbrs_pkg::DATA_W-1:0] s_target_value;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [pbrs_pkg::DATA_W-1:0] m_root_estimate;
    logic                               m_converged;

    // bench copy of the register file
    logic signed [pbrs_pkg::DATA_W-1:0] coef_q [pbrs_pkg::COEF_SLOTS];
    logic signed [pbrs_pkg::DATA_W-1:0] x_low_q;
    logic signed [pbrs_pkg::DATA_W-1:0] x_high_q;
    logic [pbrs_pkg::TOL_W-1:0]         tol_q;

    // roots still owed by the block, oldest first
    root_result_t expected_roots [$];
    stim_row_t    directed_rows [0:DIRECTED_ROWS-1];

    int error_count;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    polynomial_bisection_root_solver uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_target_value  (s_target_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_root_estimate (m_root_estimate),
        .m_converged     (m_converged)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: Q16.16 polynomial and bisection, all in 64-bit integers
    // ------------------------------------------------------------------

    // round half up back to Q16.16 (>>> on a signed longint is a floor)
    function automatic longint round_q(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp_q32(input longint v);
        if (v > longint'(Q_MAX)) begin
            return longint'(Q_MAX);
        end else if (v < longint'(Q_MIN)) begin
            return longint'(Q_MIN);
        end
        return v;
    endfunction

    // f(x): each power is rounded and clamped before it feeds the next one,
    // the terms add up at full width and only the sum is clamped
    function automatic longint poly_at(input longint x);
        longint acc;
        longint pw;
        int     k;
        acc = 0;
        pw  = x;
        for (k = 0; k < pbrs_pkg::NUM_COEFFS; k++) begin
            acc = acc + round_q(longint'(coef_q[k]) * pw);
            pw  = clamp_q32(round_q(pw * x));
        end
        return clamp_q32(acc);
    endfunction

    // bisection on the current registers; bounds are taken as given, so a
    // reversed interval or a non-monotonic f just follows the same update rule
    function automatic root_result_t solve_for(
        input logic signed [pbrs_pkg::DATA_W-1:0] target
    );
        longint       lo;
        longint       hi;
        longint       mid;
        longint       f;
        longint       err;
        longint       y;
        logic         hit;
        int           step;
        root_result_t r;
        y   = target;
        lo  = x_low_q;
        hi  = x_high_q;
        mid = 0;
        hit = 1'b0;
        for (step = 0; step < pbrs_pkg::MAX_STEPS && !hit; step++) begin
            mid = (lo + hi) >>> 1;
            f   = poly_at(mid);
            err = (f > y) ? f - y : y - f;
            // strict compare: a zero tolerance never converges
            if (err < longint'(tol_q)) begin
                hit = 1'b1;
            end else if (f < y) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        r.root      = mid[pbrs_pkg::DATA_W-1:0];
        r.converged = hit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------

    function automatic stim_row_t req_row(input logic [pbrs_pkg::DATA_W-1:0] target);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_REQ;
        r.value = target;
        return r;
    endfunction

    // request whose result is obvious from the registers alone
    function automatic stim_row_t chk_row(input logic [pbrs_pkg::DATA_W-1:0] target,
                                          input logic [pbrs_pkg::DATA_W-1:0] root,
                                          input logic                        conv);
        stim_row_t r;
        r                    = req_row(target);
        r.typed              = 1'b1;
        r.expected.root      = root;
        r.expected.converged = conv;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input pbrs_pkg::cfg_addr_t         addr,
                                          input logic [pbrs_pkg::DATA_W-1:0] value);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.addr  = addr;
        r.value = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    // one register write, then the enable drops before the task returns, so back-to-back
    // writes never assign the enable twice in one step
    task automatic write_reg(input pbrs_pkg::cfg_addr_t         addr,
                             input logic [pbrs_pkg::DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            pbrs_pkg::REG_COEF_0, pbrs_pkg::REG_COEF_1,
            pbrs_pkg::REG_COEF_2, pbrs_pkg::REG_COEF_3: begin
                coef_q[addr[pbrs_pkg::K_W-1:0]] = value;
            end
            pbrs_pkg::REG_X_LOW: begin
                x_low_q = value;
            end
            pbrs_pkg::REG_X_HIGH: begin
                x_high_q = value;
            end
            pbrs_pkg::REG_TOLERANCE: begin
                tol_q = value[pbrs_pkg::TOL_W-1:0];
            end
            default: begin
                // no register at this index, the write goes nowhere
            end
        endcase
        @(posedge aclk);
    endtask

    // hold off new requests until every owed result is back; every request
    // yields a result, so a short margin covers the return to idle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_roots.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // present one request, with a random gap first; valid is left high after
    // the handshake so the next call can follow without a bubble
    task automatic send_target(input logic signed [pbrs_pkg::DATA_W-1:0] target,
                               input logic                               typed,
                               input root_result_t                       typed_result);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_target_value <= target;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (typed) begin
            expected_roots.push_back(typed_result);
        end else begin
            expected_roots.push_back(solve_for(target));
        end
    endtask

    // mostly targets that f actually reaches inside the interval (with a
    // little jitter), the rest raw noise and the range ends
    task automatic send_random_target();
        longint                             a;
        longint                             b;
        longint                             x;
        longint                             y;
        longint                             jit;
        logic [63:0]                        r;
        logic signed [pbrs_pkg::DATA_W-1:0] t;
        if ($urandom_range(9) < 7) begin
            if (x_low_q <= x_high_q) begin
                a = x_low_q;
                b = x_high_q;
            end else begin
                a = x_high_q;
                b = x_low_q;
            end
            r   = {$urandom, $urandom};
            x   = a + longint'(r % (b - a + 1));
            jit = longint'($urandom_range(0, 64)) - 32;
            y   = clamp_q32(poly_at(x) + jit);
            t   = y[pbrs_pkg::DATA_W-1:0];
        end else if ($urandom_range(9) == 0) begin
            t = $urandom_range(1) ? Q_MAX : Q_MIN;
        end else begin
            t = $urandom;
        end
        send_target(t, 1'b0, '0);
    endtask

    // a fresh register set: every register is written each time
    task automatic load_random_setting();
        logic [pbrs_pkg::DATA_W-1:0] c [pbrs_pkg::COEF_SLOTS];
        logic [pbrs_pkg::DATA_W-1:0] lo_v;
        logic [pbrs_pkg::DATA_W-1:0] hi_v;
        logic [pbrs_pkg::DATA_W-1:0] tol_v;
        logic [pbrs_pkg::DATA_W-1:0] swap_v;
        int                          k;
        case ($urandom_range(3))
            0: begin
                // increasing on a positive interval
                c[0] = $urandom_range(32'h0000_1000, 32'h0004_0000);
                for (k = 1; k < pbrs_pkg::COEF_SLOTS; k++) begin
                    c[k] = $urandom_range(0, 32'h0000_8000);
                end
                lo_v = $urandom_range(0, 32'h0001_0000);
                hi_v = lo_v + $urandom_range(1, 32'h0004_0000);
            end
            1: begin
                // anything at all, extremes included
                for (k = 0; k < pbrs_pkg::COEF_SLOTS; k++) begin
                    c[k] = $urandom;
                end
                lo_v = $urandom;
                hi_v = $urandom;
            end
            2: begin
                // decreasing on [0, up to 2.0]
                c[0] = -$urandom_range(32'h0000_1000, 32'h0004_0000);
                for (k = 1; k < pbrs_pkg::COEF_SLOTS; k++) begin
                    c[k] = -$urandom_range(0, 32'h0000_8000);
                end
                lo_v = 32'h0;
                hi_v = $urandom_range(32'h0000_4000, 32'h0002_0000);
            end
            default: begin
                // small mixed-sign coefficients, often non-monotonic
                for (k = 0; k < pbrs_pkg::COEF_SLOTS; k++) begin
                    c[k] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                end
                lo_v = -$urandom_range(0, 32'h0003_0000);
                hi_v = $urandom_range(0, 32'h0003_0000);
            end
        endcase
        // now and then run the search with the bounds swapped
        if ($urandom_range(4) == 0) begin
            swap_v = lo_v;
            lo_v   = hi_v;
            hi_v   = swap_v;
        end
        case ($urandom_range(7))
            0: tol_v = 32'h0;
            1: tol_v = 32'h7fff_ffff;
            2: tol_v = $urandom;
            default: tol_v = $urandom_range(1, 2000);
        endcase
        write_reg(pbrs_pkg::REG_COEF_0, c[0]);
        write_reg(pbrs_pkg::REG_COEF_1, c[1]);
        write_reg(pbrs_pkg::REG_COEF_2, c[2]);
        write_reg(pbrs_pkg::REG_COEF_3, c[3]);
        write_reg(pbrs_pkg::REG_X_LOW, lo_v);
        write_reg(pbrs_pkg::REG_X_HIGH, hi_v);
        write_reg(pbrs_pkg::REG_TOLERANCE, tol_v);
        if ($urandom_range(3) == 0) begin
            write_reg(REG_UNUSED, $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random backpressure and the scoreboard check
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_results
        root_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_roots.size() == 0) begin
                note_failure($sformatf("unexpected result: root %h converged %0d",
                                       m_root_estimate, m_converged));
            end else begin
                want = expected_roots.pop_front();
                if (m_root_estimate !== want.root) begin
                    note_failure($sformatf("root_estimate mismatch: expected %h got %h",
                                           want.root, m_root_estimate));
                end
                if (m_converged !== want.converged) begin
                    note_failure($sformatf("converged mismatch: expected %0d got %0d",
                                           want.converged, m_converged));
                end
            end
        end
    end

    // hang detector: any handshake or register write counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("polynomial_bisection_root_solver test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : run
        int phase;
        int setting;
        int item;
        int row;

        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = pbrs_pkg::REG_COEF_0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_target_value = '0;
        m_ready        = 1'b0;
        error_count    = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // register values after reset: f(x) = x on [0, 1.0], tolerance 66
        coef_q[0] = pbrs_pkg::Q_ONE;
        coef_q[1] = pbrs_pkg::Q_ZERO;
        coef_q[2] = pbrs_pkg::Q_ZERO;
        coef_q[3] = pbrs_pkg::Q_ZERO;
        x_low_q   = pbrs_pkg::Q_ZERO;
        x_high_q  = pbrs_pkg::Q_ONE;
        tol_q     = pbrs_pkg::TOL_RESET;

        directed_rows = '{
            // reset registers: exact hit on the first midpoint
            chk_row(32'h0000_8000, 32'h0000_8000, 1'b1),
            // target above f's reach: lower bound creeps up to one lsb below 1.0
            chk_row(Q_MAX, 32'h0000_ffff, 1'b0),
            // target below f's reach: upper bound falls to zero
            chk_row(Q_MIN, 32'h0000_0000, 1'b0),
            req_row(32'h0001_0000),
            req_row(32'hffff_ffff),
            req_row(32'h0000_3039),
            // write to an index with no register must change nothing
            cfg_row(REG_UNUSED, 32'hffff_ffff),
            chk_row(32'h0000_8000, 32'h0000_8000, 1'b1),
            // zero tolerance: never converges, even on an exact hit
            cfg_row(pbrs_pkg::REG_TOLERANCE, 32'h0000_0000),
            req_row(32'h0000_8000),
            chk_row(Q_MIN, 32'h0000_0000, 1'b0),
            // widest tolerance: almost anything passes on the first try
            cfg_row(pbrs_pkg::REG_TOLERANCE, 32'h7fff_ffff),
            chk_row(32'h0000_0000, 32'h0000_8000, 1'b1),
            req_row(Q_MIN),
            // reversed interval
            cfg_row(pbrs_pkg::REG_TOLERANCE, 32'd66),
            cfg_row(pbrs_pkg::REG_X_LOW, 32'h0001_0000),
            cfg_row(pbrs_pkg::REG_X_HIGH, 32'h0000_0000),
            req_row(32'h0000_4000),
            req_row(32'h0000_c000),
            // non-monotonic: f(x) = x^3 - x on [-2.0, 2.0]
            cfg_row(pbrs_pkg::REG_COEF_0, 32'hffff_0000),
            cfg_row(pbrs_pkg::REG_COEF_2, 32'h0001_0000),
            cfg_row(pbrs_pkg::REG_X_LOW, 32'hfffe_0000),
            cfg_row(pbrs_pkg::REG_X_HIGH, 32'h0002_0000),
            chk_row(32'h0000_0000, 32'h0000_0000, 1'b1),
            req_row(32'h0000_6000),
            req_row(32'hffff_63c0),
            // extreme coefficients and the full interval: saturation everywhere
            cfg_row(pbrs_pkg::REG_COEF_0, Q_MAX),
            cfg_row(pbrs_pkg::REG_COEF_1, Q_MAX),
            cfg_row(pbrs_pkg::REG_COEF_2, Q_MAX),
            cfg_row(pbrs_pkg::REG_COEF_3, Q_MIN),
            cfg_row(pbrs_pkg::REG_X_LOW, Q_MIN),
            cfg_row(pbrs_pkg::REG_X_HIGH, Q_MAX),
            req_row(Q_MAX),
            req_row(Q_MIN),
            req_row(32'h0000_0000),
            req_row(32'h0000_ffff)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling on either side
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed_rows[row].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[row].addr, directed_rows[row].value);
            end else begin
                send_target(directed_rows[row].value, directed_rows[row].typed,
                            directed_rows[row].expected);
            end
        end

        // random requests: free flow, sender gaps, receiver stalls, then both;
        // each phase walks through a few register sets, draining in between
        for (phase = 0; phase < IDLE_PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            for (setting = 0; setting < SETTINGS_PER_PHASE; setting++) begin
                wait_idle();
                load_random_setting();
                for (item = 0; item < ITEMS_PER_SETTING; item++) begin
                    send_random_target();
                end
            end
        end

        // drain, then watch a full worst-case latency for stray results
        wait_idle();
        repeat (SOLVE_CYCLES_MAX) @(posedge aclk);

        if (expected_roots.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_roots.size()));
        end

        if (error_count == 0) begin
            $display("polynomial_bisection_root_solver test passed");
        end else begin
            $display("polynomial_bisection_root_solver test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/pbrs_pkg.sv
design/pbrs_sequencer.sv
design/pbrs_datapath.sv
design/polynomial_bisection_root_solver.sv
tb/tb.sv
